FILE: src/gbn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;

  localparam int SEQ_W      = 16;
  localparam int MAX_WINDOW = 16;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int WS_W       = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_W      = 16;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_TIMEOUT = 2'd1,
    ACT_ACK     = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL  = 2'd0,
    REG_WINDOW = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]       action;
    logic [SEQ_W-1:0] ack_number;
  } in_t;

  typedef struct packed {
    logic             send_valid;
    logic [SEQ_W-1:0] packet_number;
    logic             retransmit;
    logic             last_of_run;
    logic             finished;
  } out_t;

  // One event's worth of work for the emitter; count zero means a status result.
  typedef struct packed {
    logic [SEQ_W-1:0] first_pkt;
    logic [CNT_W-1:0] count;
    logic             retx;
    logic             fin;
  } job_t;

endpackage
`default_nettype wire

FILE: src/gbn_front.sv
`timescale 1ns / 1ps
`default_nettype none
module gbn_front import gbn_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  input  wire logic                 q_full,
  output logic                      push,
  output job_t                      job
);

  logic [SEQ_W-1:0] total_packets;
  logic [WS_W-1:0]  window_size;
  logic [SEQ_W-1:0] base, base_next;
  logic [SEQ_W-1:0] wend, wend_next;
  logic             started, started_next;

  logic             fin_now;
  logic [CNT_W-1:0] w_clamp;
  logic [SEQ_W-1:0] w_total;
  logic [SEQ_W-1:0] span;
  logic [CNT_W-1:0] span_cnt;
  logic [SEQ_W-1:0] base_inc;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_packets <= SEQ_W'(5);
      window_size   <= WS_W'(3);
    end else if (cfg_valid) begin
      if (cfg_index == REG_TOTAL) begin
        total_packets <= cfg_data[SEQ_W-1:0];
      end else if (cfg_index == REG_WINDOW) begin
        window_size <= cfg_data[WS_W-1:0];
      end
    end
  end

  assign fin_now  = started && (base == wend);
  assign base_inc = base + SEQ_W'(1);
  assign span     = wend - base;
  assign span_cnt = (span > SEQ_W'(MAX_WINDOW)) ? CNT_W'(MAX_WINDOW) : CNT_W'(span);

  always_comb begin
    if (window_size == '0) begin
      w_clamp = CNT_W'(1);
    end else if (int'(window_size) > MAX_WINDOW) begin
      w_clamp = CNT_W'(MAX_WINDOW);
    end else begin
      w_clamp = CNT_W'(window_size);
    end
    w_total = (SEQ_W'(w_clamp) > total_packets) ? total_packets : SEQ_W'(w_clamp);
  end

  always_comb begin
    base_next     = base;
    wend_next     = wend;
    started_next  = started;
    job.first_pkt = '0;
    job.count     = '0;
    job.retx      = 1'b0;
    job.fin       = 1'b0;
    priority if (fin_now || in_data.action == ACT_NONE) begin
      job.fin = fin_now;
    end else if (in_data.action == ACT_START) begin
      if (!started) begin
        started_next  = 1'b1;
        base_next     = '0;
        wend_next     = w_total;
        job.first_pkt = SEQ_W'(1);
        job.count     = CNT_W'(w_total);
        job.fin       = (w_total == '0);
      end
    end else if (!started) begin
      job.fin = 1'b0;
    end else if (in_data.action == ACT_TIMEOUT || in_data.ack_number != base_inc) begin
      job.first_pkt = base_inc;
      job.count     = span_cnt;
      job.retx      = 1'b1;
    end else begin
      base_next = base_inc;
      if (wend < total_packets) begin
        wend_next     = wend + SEQ_W'(1);
        job.first_pkt = wend + SEQ_W'(1);
        job.count     = CNT_W'(1);
      end else begin
        job.fin = (base_inc == wend);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base    <= '0;
      wend    <= '0;
      started <= 1'b0;
    end else if (push) begin
      base    <= base_next;
      wend    <= wend_next;
      started <= started_next;
    end
  end

  a_base_le_end: assert property (@(posedge clk) disable iff (rst) base <= wend)
    else $error("window base passed window end");
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    !started |-> (base == '0 && wend == '0))
    else $error("window state moved before start");
  a_job_bound: assert property (@(posedge clk) disable iff (rst)
    push |-> job.count <= CNT_W'(MAX_WINDOW))
    else $error("job longer than the window");

endmodule
`default_nettype wire

FILE: src/gbn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module gbn_queue import gbn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output job_t      q_job
);

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("pop from empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers out of step with count");

endmodule
`default_nettype wire

FILE: src/gbn_back.sv
`timescale 1ns / 1ps
`default_nettype none
module gbn_back import gbn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire job_t q_job,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic             busy;
  logic             status;
  logic [SEQ_W-1:0] cur_pkt;
  logic [CNT_W-1:0] remain;
  logic             retx;
  logic             fin;
  logic             out_ok;
  logic             emit;
  logic             done;

  assign out_ok = !out_valid || !out_stall;
  assign emit   = busy && out_ok;
  assign done   = status || (remain == CNT_W'(1));
  assign pop    = !busy && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_ok) begin
        out_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
      end else if (emit && done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status  <= (q_job.count == '0);
      cur_pkt <= q_job.first_pkt;
      remain  <= q_job.count;
      retx    <= q_job.retx;
      fin     <= q_job.fin;
    end else if (emit && !done) begin
      cur_pkt <= cur_pkt + SEQ_W'(1);
      remain  <= remain - CNT_W'(1);
    end
    if (emit) begin
      if (status) begin
        out_data <= '{send_valid: 1'b0, packet_number: '0, retransmit: 1'b0,
                      last_of_run: 1'b1, finished: fin};
      end else begin
        out_data <= '{send_valid: 1'b1, packet_number: cur_pkt, retransmit: retx,
                      last_of_run: done, finished: fin};
      end
    end
  end

  a_run_nonempty: assert property (@(posedge clk) disable iff (rst)
    (busy && !status) |-> remain != '0)
    else $error("send run with nothing left");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("output changed while stalled");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst) busy |-> !pop)
    else $error("job taken while a run is active");

endmodule
`default_nettype wire

FILE: src/go_back_n_sender_window.sv
// An accepted event reaches out_valid through the queue write, the emitter load from the
// queue and then the output register; a busy emitter or a stalled output holds it back.
// Throughput: an event producing n results (n = 1..16) holds the emitter until its last
// result is out; the output register gives one result per cycle while not stalled.
// Reset (rst, synchronous): window empty and not started, total_packets = 5,
// window_size = 3, queue and output register empty.
`timescale 1ns / 1ps
`default_nettype none
module go_back_n_sender_window import gbn_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_t                  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_t                      out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic push;
  job_t push_job;
  logic q_full;
  logic q_valid;
  job_t q_job;
  logic pop;

  assign cfg_ready = 1'b1;

  gbn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .job       (push_job)
  );

  gbn_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  gbn_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: tb/sv/gbn_window_checker.sv
`timescale 1ns / 1ps
module gbn_window_checker import gbn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_t                  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_t                 out_data,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   mismatches,
  output int                   pending,
  output int                   checked
);

  logic [SEQ_W-1:0] total_cfg;
  logic [WS_W-1:0]  window_cfg;
  logic [SEQ_W-1:0] win_base;
  logic [SEQ_W-1:0] win_end;
  bit               opened;
  out_t             expected_sends[$];
  int               err_cnt = 0;
  int               seen_cnt = 0;

  task automatic queue_result(bit snd, logic [SEQ_W-1:0] pkt, bit rtx, bit last);
    out_t r;
    r.send_valid    = snd;
    r.packet_number = pkt;
    r.retransmit    = rtx;
    r.last_of_run   = last;
    // finished reflects the state after the event has been applied
    r.finished      = opened && (win_base == win_end);
    expected_sends.push_back(r);
  endtask

  task automatic queue_window(bit rtx);
    int cnt;
    int i;
    cnt = int'(win_end) - int'(win_base);
    if (cnt > MAX_WINDOW) cnt = MAX_WINDOW;
    if (cnt <= 0) begin
      queue_result(1'b0, '0, 1'b0, 1'b1);
    end else begin
      for (i = 0; i < cnt; i++)
        queue_result(1'b1, win_base + SEQ_W'(i + 1), rtx, i == cnt - 1);
    end
  endtask

  task automatic predict_event(in_t ev);
    logic [SEQ_W-1:0] w;
    if ((opened && win_base == win_end) || ev.action == ACT_NONE) begin
      queue_result(1'b0, '0, 1'b0, 1'b1);
    end else if (ev.action == ACT_START) begin
      if (opened) begin
        queue_result(1'b0, '0, 1'b0, 1'b1);
      end else begin
        w = SEQ_W'(window_cfg);
        if (w == '0) w = SEQ_W'(1);
        if (w > SEQ_W'(MAX_WINDOW)) w = SEQ_W'(MAX_WINDOW);
        if (w > total_cfg) w = total_cfg;
        opened   = 1'b1;
        win_base = '0;
        win_end  = w;
        queue_window(1'b0);
      end
    end else if (!opened) begin
      queue_result(1'b0, '0, 1'b0, 1'b1);
    end else if (ev.action == ACT_TIMEOUT || ev.ack_number != win_base + 1'b1) begin
      queue_window(1'b1);
    end else begin
      win_base = win_base + 1'b1;
      // end only grows while below the current total
      if (win_end < total_cfg) begin
        win_end = win_end + 1'b1;
        queue_result(1'b1, win_end, 1'b0, 1'b1);
      end else begin
        queue_result(1'b0, '0, 1'b0, 1'b1);
      end
    end
  endtask

  task automatic compare_field(string name, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
    if (got !== want) begin
      err_cnt++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endtask

  task automatic check_result(out_t got);
    out_t want;
    seen_cnt++;
    if (expected_sends.size() == 0) begin
      err_cnt++;
      $error("unexpected transaction: packet_number %0d", got.packet_number);
    end else begin
      want = expected_sends.pop_front();
      compare_field("send_valid", want.send_valid, got.send_valid);
      compare_field("packet_number", want.packet_number, got.packet_number);
      compare_field("retransmit", want.retransmit, got.retransmit);
      compare_field("last_of_run", want.last_of_run, got.last_of_run);
      compare_field("finished", want.finished, got.finished);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      total_cfg  = 16'd5;
      window_cfg = 5'd3;
      win_base   = '0;
      win_end    = '0;
      opened     = 1'b0;
      expected_sends.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TOTAL) total_cfg = cfg_data;
        else if (cfg_index == REG_WINDOW) window_cfg = cfg_data[WS_W-1:0];
      end
      if (in_valid && !in_stall) predict_event(in_data);
    end
    pending    <= expected_sends.size();
    mismatches <= err_cnt;
    checked    <= seen_cnt;
  end

endmodule

FILE: tb/sv/tb_go_back_n_sender_window.sv
`timescale 1ns / 1ps
module tb_go_back_n_sender_window;
  import gbn_pkg::*;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_t                  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TOTAL;
  logic [CFG_W-1:0]     cfg_data = '0;

  int               mismatches;
  int               pending;
  int               checked;
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               events_sent = 0;
  bit               session_open = 1'b0;
  logic [SEQ_W-1:0] next_ack = 16'd1;

  go_back_n_sender_window uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gbn_window_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays high between back-to-back transactions; it only drops for a gap
  task automatic send_event(action_t act, logic [SEQ_W-1:0] ack);
    in_t ev;
    ev.action     = act;
    ev.ack_number = ack;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    events_sent++;
    if (act == ACT_START) session_open = 1'b1;
    else if (session_open && act == ACT_ACK && ack == next_ack) next_ack = next_ack + 1'b1;
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly in-order acks so the window keeps sliding deep into the sequence
  task automatic random_event();
    int r;
    r = $urandom_range(99);
    if (r < 66) send_event(ACT_ACK, next_ack);
    else if (r < 76) send_event(ACT_TIMEOUT, 16'($urandom));
    else if (r < 82) send_event(ACT_ACK, 16'($urandom));
    else if (r < 88) send_event(ACT_ACK, next_ack + 16'($urandom_range(1, 3)));
    else if (r < 91) send_event(ACT_ACK, next_ack - 16'd1);
    else if (r < 96) send_event(ACT_NONE, 16'($urandom));
    else send_event(ACT_START, 16'($urandom));
  endtask

  initial begin
    int ph;
    int i;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    idle_pct  = 15;
    stall_pct = 15;
    // events before start are ignored
    send_event(ACT_TIMEOUT, 16'hFFFF);
    send_event(ACT_ACK, 16'd1);
    send_event(ACT_ACK, 16'd0);
    send_event(ACT_NONE, 16'h5A5A);
    drain_outputs();

    cfg_write(REG_TOTAL, 16'd0);
    cfg_write(REG_WINDOW, 16'd0);
    cfg_write(REG_TOTAL, 16'hFFFF);
    cfg_write(REG_WINDOW, 16'd31);
    // window above max clamps to 16, then to the total
    cfg_write(REG_TOTAL, 16'($urandom_range(8, 15)));

    send_event(ACT_START, 16'h0000);
    send_event(ACT_TIMEOUT, 16'h0000);
    send_event(ACT_ACK, next_ack);
    send_event(ACT_ACK, 16'hFFFF);
    send_event(ACT_NONE, 16'hA5A5);
    send_event(ACT_START, 16'hFFFF);
    send_event(ACT_ACK, next_ack + 16'd2);
    drain_outputs();

    cfg_write(REG_TOTAL, 16'hFFFF);
    send_event(ACT_ACK, next_ack);
    send_event(ACT_TIMEOUT, 16'hFFFF);
    drain_outputs();

    // total dropped under the window end: acks slide without new sends
    cfg_write(REG_TOTAL, 16'd0);
    send_event(ACT_ACK, next_ack);
    send_event(ACT_ACK, next_ack);
    send_event(ACT_TIMEOUT, 16'h0000);
    drain_outputs();
    cfg_write(REG_TOTAL, 16'hFFFF);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 77;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 77;
        end
        default: begin
          idle_pct  = 15;
          stall_pct = 15;
        end
      endcase
      for (i = 0; i < 30; i++) random_event();
      drain_outputs();
      cfg_write(REG_WINDOW, 16'($urandom_range(0, 31)));
      cfg_write(REG_TOTAL, 16'($urandom_range(20000, 65535)));
    end

    // close the session: no growth left, so in-order acks run the window dry
    cfg_write(REG_TOTAL, 16'd0);
    for (i = 0; i < 20; i++) send_event(ACT_ACK, next_ack);
    send_event(ACT_TIMEOUT, 16'hFFFF);
    send_event(ACT_START, 16'h0000);
    send_event(ACT_NONE, 16'h0000);
    drain_outputs();
    repeat (10) @(posedge clk);

    $display("Sent %0d events through one sender session, %0d results compared",
             events_sent, checked);
    $display("Covered start clamps, resends, stale and in-order acks, no-growth and finish");
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
